### rtl/icc_pkg.sv
// Shared constants, command codes and control structs for the interval chain cover check.
// No dependencies; icc_ifs, icc_walk and the top level import this package.
package icc_pkg;

   localparam int ICC_MAX_BLOCKS = 64;
   localparam int ICC_COORD_BITS = 31;

   // Command codes of the request word.
   localparam logic [1:0] CMD_TESTED = 2'd0;
   localparam logic [1:0] CMD_COVER  = 2'd1;
   localparam logic [1:0] CMD_EVAL   = 2'd2;

   // Control from the top level to the chain walker.
   typedef struct packed {
      logic start;       // begin an evaluation
      logic exact;       // one-to-one pairing with equal interior edges
      logic force_fail;  // a chain overflowed: answer not covered at once
      logic ack;         // the result register can take the answer
   } walk_ctrl_type;

   // Status from the chain walker to the top level.
   typedef struct packed {
      logic idle;
      logic done;
      logic covered;
   } walk_stat_type;

endpackage

### rtl/icc_ifs.sv
// Valid/ready channel interfaces of the interval chain cover check: request, response, CSR.
// Depends on icc_pkg for the default coordinate width.
interface icc_req_if import icc_pkg::*; #(
   parameter int COORD_BITS = ICC_COORD_BITS
);
   logic                  valid;
   logic                  ready;
   logic [1:0]            cmd;
   logic [COORD_BITS-1:0] block_start;
   logic [COORD_BITS-1:0] block_end;

   modport source (output valid, cmd, block_start, block_end, input ready);
   modport sink   (input valid, cmd, block_start, block_end, output ready);
endinterface

interface icc_rsp_if;
   logic valid;
   logic ready;
   logic covered;
   logic overflow;

   modport source (output valid, covered, overflow, input ready);
   modport sink   (input valid, covered, overflow, output ready);
endinterface

interface icc_csr_if;
   logic valid;
   logic ready;
   logic exact_mode;

   modport source (output valid, exact_mode, input ready);
   modport sink   (input valid, exact_mode, output ready);
endinterface

### rtl/icc_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module icc_ram #(
   parameter int WIDTH = 62,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/icc_walk.sv
// Two-pointer chain walker: steps through the tested and covering stores and decides coverage.
// Depends on icc_pkg; reads both chain RAMs through their registered read ports.
module icc_walk import icc_pkg::*; #(
   parameter int MAX_BLOCKS = ICC_MAX_BLOCKS,
   parameter int COORD_BITS = ICC_COORD_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  walk_ctrl_type                   ctrl,
   output walk_stat_type                   stat,
   input  logic [$clog2(MAX_BLOCKS+1)-1:0] tested_count,
   input  logic [$clog2(MAX_BLOCKS+1)-1:0] cover_count,
   output logic [$clog2(MAX_BLOCKS)-1:0]   tested_addr,
   output logic [$clog2(MAX_BLOCKS)-1:0]   cover_addr,
   input  logic [2*COORD_BITS-1:0]         tested_data,
   input  logic [2*COORD_BITS-1:0]         cover_data
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS+1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_CMP   = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [CNT_W-1:0]      ti_ff, ti_in;
   logic [CNT_W-1:0]      cj_ff, cj_in;
   logic                  covered_ff, covered_in;
   logic                  exact_ff, exact_in;

   logic [COORD_BITS-1:0] t_lo, t_hi, m_lo, m_hi;
   logic                  contains;
   logic                  edge_bad;
   logic                  not_last;

   // Words are stored as {end, start}.
   assign t_lo = tested_data[COORD_BITS-1:0];
   assign t_hi = tested_data[2*COORD_BITS-1:COORD_BITS];
   assign m_lo = cover_data[COORD_BITS-1:0];
   assign m_hi = cover_data[2*COORD_BITS-1:COORD_BITS];

   assign contains = (m_lo <= t_lo) && (m_hi >= t_hi);
   assign not_last = ({1'b0, ti_ff} + (CNT_W+1)'(1)) < {1'b0, tested_count};
   assign edge_bad = exact_ff && (((ti_ff != '0) && (m_lo != t_lo)) ||
                                  (not_last && (m_hi != t_hi)));

   assign tested_addr = ti_ff[IDX_W-1:0];
   assign cover_addr  = cj_ff[IDX_W-1:0];

   always_comb begin
      state_in   = state_ff;
      ti_in      = ti_ff;
      cj_in      = cj_ff;
      covered_in = covered_ff;
      exact_in   = exact_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctrl.start) begin
               ti_in    = '0;
               cj_in    = '0;
               exact_in = ctrl.exact;
               if (ctrl.force_fail) begin
                  covered_in = 1'b0;
                  state_in   = ST_DONE;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (ti_ff >= tested_count) begin
               covered_in = 1'b1;
               state_in   = ST_DONE;
            end else if (cj_ff >= cover_count) begin
               covered_in = 1'b0;
               state_in   = ST_DONE;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (contains && !edge_bad) begin
               ti_in    = ti_ff + CNT_W'(1);
               cj_in    = cj_ff + CNT_W'(exact_ff);
               state_in = ST_CHECK;
            end else if (contains || (m_lo > t_lo) || exact_ff) begin
               covered_in = 1'b0;
               state_in   = ST_DONE;
            end else begin
               cj_in    = cj_ff + CNT_W'(1);
               state_in = ST_CHECK;
            end
         end
         ST_DONE: begin
            if (ctrl.ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ti_ff      <= ti_in;
      cj_ff      <= cj_in;
      covered_ff <= covered_in;
      exact_ff   <= exact_in;
   end

   assign stat.idle    = (state_ff == ST_IDLE);
   assign stat.done    = (state_ff == ST_DONE);
   assign stat.covered = covered_ff;

endmodule

### rtl/interval_chain_cover_check.sv
// Top level of the interval chain cover check: loads, chain counts, CSR and response register.
// Depends on icc_pkg, the channel interfaces in icc_ifs, icc_ram and icc_walk.
//
//   Channel   Direction  Word carried
//   req       in         cmd, block_start, block_end
//   rsp       out        covered, overflow (one word per evaluate)
//   csr       in         exact_mode
//
// A load (append tested or covering block) writes its word into the chain RAM, and the next
// word can follow directly. An evaluate runs the two-pointer walk, whose number of compare
// steps is at most tested_count + cover_count; each step is a read of the two chain RAMs
// through their registered read ports, then a compare. A walk may stop early on a failed
// compare, and an evaluate after an overflow answers not covered without a walk. Reset
// clears the counts, the overflow flag, exact_mode and the handshake state; the RAMs are
// not cleared, because only entries below the counts are ever read. A stalled response
// holds the walker in its final state, while loads are still taken once the walker is
// idle.
module interval_chain_cover_check import icc_pkg::*; #(
   parameter int MAX_BLOCKS = ICC_MAX_BLOCKS,
   parameter int COORD_BITS = ICC_COORD_BITS
) (
   input  logic       clock,
   input  logic       reset,
   icc_req_if.sink    req,
   icc_rsp_if.source  rsp,
   icc_csr_if.sink    csr
);

   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int CNT_W  = $clog2(MAX_BLOCKS+1);
   localparam int WORD_W = 2*COORD_BITS;

   // Configuration register; writes must arrive only while the block is idle, which the block does not enforce.
   logic exact_ff, exact_in;

   // Chain fill counts and the sticky overflow flag.
   logic [CNT_W-1:0] tested_count_ff, tested_count_in;
   logic [CNT_W-1:0] cover_count_ff, cover_count_in;
   logic             overflow_ff, overflow_in;

   // Response register, which decouples the walker from a stalled consumer.
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_covered_ff, rsp_covered_in;
   logic rsp_overflow_ff, rsp_overflow_in;

   logic             req_accept;
   logic             tested_full, cover_full;
   logic             tested_wr, cover_wr;
   logic [WORD_W-1:0] block_word;
   logic [IDX_W-1:0] tested_rd_addr, cover_rd_addr;
   logic [WORD_W-1:0] tested_rd_data, cover_rd_data;
   logic             rsp_free;

   walk_ctrl_type walk_ctrl;
   walk_stat_type walk_stat;

   assign csr.ready  = 1'b1;
   assign req.ready  = walk_stat.idle;
   assign req_accept = req.valid && req.ready;

   assign tested_full = (tested_count_ff >= CNT_W'(MAX_BLOCKS));
   assign cover_full  = (cover_count_ff >= CNT_W'(MAX_BLOCKS));
   assign block_word  = {req.block_end, req.block_start};

   // The response register can take a new word when empty or drained this cycle.
   assign rsp_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      tested_wr = 1'b0;
      cover_wr  = 1'b0;
      walk_ctrl = '0;
      walk_ctrl.exact      = exact_ff;
      walk_ctrl.force_fail = overflow_ff;
      walk_ctrl.ack        = rsp_free;

      exact_in        = exact_ff;
      tested_count_in = tested_count_ff;
      cover_count_in  = cover_count_ff;
      overflow_in     = overflow_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      rsp_covered_in  = rsp_covered_ff;
      rsp_overflow_in = rsp_overflow_ff;

      if (csr.valid && csr.ready) begin
         exact_in = csr.exact_mode;
      end

      if (req_accept) begin
         case (req.cmd)
            CMD_TESTED: begin
               if (tested_full) begin
                  overflow_in = 1'b1;
               end else begin
                  tested_wr       = 1'b1;
                  tested_count_in = tested_count_ff + CNT_W'(1);
               end
            end
            CMD_COVER: begin
               if (cover_full) begin
                  overflow_in = 1'b1;
               end else begin
                  cover_wr       = 1'b1;
                  cover_count_in = cover_count_ff + CNT_W'(1);
               end
            end
            CMD_EVAL: begin
               walk_ctrl.start = 1'b1;
            end
            default: begin
               // The unused command code is dropped without any effect.
            end
         endcase
      end

      // The answer leaves the walker; both chains and the overflow flag start over.
      if (walk_stat.done && rsp_free) begin
         rsp_valid_in    = 1'b1;
         rsp_covered_in  = walk_stat.covered;
         rsp_overflow_in = overflow_ff;
         tested_count_in = '0;
         cover_count_in  = '0;
         overflow_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exact_ff        <= 1'b0;
         tested_count_ff <= '0;
         cover_count_ff  <= '0;
         overflow_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         exact_ff        <= exact_in;
         tested_count_ff <= tested_count_in;
         cover_count_ff  <= cover_count_in;
         overflow_ff     <= overflow_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_covered_ff  <= rsp_covered_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.covered  = rsp_covered_ff;
   assign rsp.overflow = rsp_overflow_ff;

   // Tested chain store.
   icc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_BLOCKS)
   ) u_tested_ram (
      .clock   (clock),
      .wr_en   (tested_wr),
      .wr_addr (tested_count_ff[IDX_W-1:0]),
      .wr_data (block_word),
      .rd_addr (tested_rd_addr),
      .rd_data (tested_rd_data)
   );

   // Covering chain store.
   icc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_BLOCKS)
   ) u_cover_ram (
      .clock   (clock),
      .wr_en   (cover_wr),
      .wr_addr (cover_count_ff[IDX_W-1:0]),
      .wr_data (block_word),
      .rd_addr (cover_rd_addr),
      .rd_data (cover_rd_data)
   );

   // Two-pointer walk over both stores.
   icc_walk #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .COORD_BITS (COORD_BITS)
   ) u_walk (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (walk_ctrl),
      .stat         (walk_stat),
      .tested_count (tested_count_ff),
      .cover_count  (cover_count_ff),
      .tested_addr  (tested_rd_addr),
      .cover_addr   (cover_rd_addr),
      .tested_data  (tested_rd_data),
      .cover_data   (cover_rd_data)
   );

endmodule
